// ===== sv/timer_min_heap_engine_defines.svh =====
// assertion macros shared by the checker of the timer heap engine
// depends on nothing; included by files that assert
`ifndef TIMER_MIN_HEAP_ENGINE_DEFINES_SVH
`define TIMER_MIN_HEAP_ENGINE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TMH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication checked at every edge, reset included
`define TMH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/tmh_pkg.sv =====
// package of the timer heap engine: sizes, codes and state type
// depends on nothing
package tmh_pkg;
   localparam int CAPACITY_DEF  = 32;
   localparam int KEY_COUNT_DEF = 1024;
   localparam int TIME_BITS_DEF = 32;
   localparam int KEY_W  = 10;
   localparam int TIME_W = 32;
   localparam int REM_W  = 33;

   typedef enum logic [1:0] {
      MODE_ARM = 2'd0, MODE_MODIFY = 2'd1, MODE_CANCEL = 2'd2, MODE_SERVICE = 2'd3
   } mode_type;
   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0, KIND_FIRED = 2'd1, KIND_REPORT = 2'd2, KIND_UNUSED = 2'd3
   } kind_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_UNUSED = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_LOOK_W, S_DISPATCH, S_WRITE_NEW,
      S_RM_RD, S_RM_RD_W, S_RM_WR,
      S_DN_RD, S_DN_RD_W, S_DN_CMP, S_DN_CMP_W, S_DN_PICK,
      S_UP_RD, S_UP_RD_W, S_UP_CMP, S_UP_CMP_W, S_UP_DEC,
      S_SWAP_A, S_SWAP_B, S_SWAP_C,
      S_SV_RD, S_SV_RD_W, S_SV_CHK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [KEY_W-1:0] fired_key;
      logic [1:0]      status;
      logic [REM_W-1:0] remaining;
      logic            none_pending;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
      logic [TIME_W-1:0] timeout;
      logic [TIME_W-1:0] now_time;
   } req_type;
endpackage

// ===== sv/tmh_if.sv =====
// valid/ready channel interface carrying one payload of any type
// depends on nothing; the payload type is a parameter
interface tmh_if #(parameter type PAYLOAD_TYPE = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/timer_min_heap_engine.sv =====
// top level of the timer heap engine: sequencer, heap and key tables
// depends on tmh_pkg, tmh_if and tmh_ram
//
//  channel   dir  handshake          payload
//  req       in   req.valid/ready    mode, key, timeout, now_time
//  rsp       out  rsp.valid/ready    kind, fired_key, status, remaining, none_pending, last
//
// a status-only answer passes S_LOOK, S_LOOK_W and S_DISPATCH before S_EMIT offers it;
// each heap level sifted reads and compares, then swaps in S_SWAP_A, S_SWAP_B and S_SWAP_C.
// a removal moves the last entry in; service checks the root ahead of each event it emits.
// after reset a clearing pass empties all KEY_COUNT (1024) entries of the key table.
// the engine stays busy while a result waits on rsp.ready.
module timer_min_heap_engine
   import tmh_pkg::*;
#(
   parameter int CAPACITY  = tmh_pkg::CAPACITY_DEF,
   parameter int KEY_COUNT = tmh_pkg::KEY_COUNT_DEF,
   parameter int TIME_BITS = tmh_pkg::TIME_BITS_DEF
) (
   input logic clock,
   input logic reset,
   tmh_if.sink   req,
   tmh_if.source rsp
);
   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = $clog2(KEY_COUNT);
   localparam int EW = TIME_BITS + 1;
   localparam int HW = KW + EW;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0]      mode_ff, mode_in;
   logic [KW-1:0]   key_ff, key_in;
   logic            kval_ff, kval_in;
   logic [EW-1:0]   exp_ff, exp_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SW-1:0]   i_ff, i_in, c_ff, c_in, start_ff, start_in;
   logic [HW-1:0]   ent_i_ff, ent_i_in, ent_c_ff, ent_c_in;
   logic            down_ff, down_in;
   logic [KW-1:0]   clr_ff, clr_in;
   rsp_type         out_ff, out_in;
   logic            ovalid_ff, ovalid_in;

   // heap store: key and expiry packed
   logic          h_we;
   logic [SW-1:0] h_wa, h_ra;
   logic [HW-1:0] h_wd, h_rd;
   tmh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   // key to slot table, top bit marks the key as held
   logic          p_we;
   logic [KW-1:0] p_wa, p_ra;
   logic [SW:0]   p_wd, p_rd;
   tmh_ram #(.WIDTH(SW + 1), .DEPTH(KEY_COUNT)) u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   // field helpers
   function automatic logic [EW-1:0] exp_of(input logic [HW-1:0] e);
      return e[EW-1:0];
   endfunction
   function automatic logic [KW-1:0] key_of(input logic [HW-1:0] e);
      return e[HW-1:EW];
   endfunction

   logic [CW:0] child_l, child_r;
   assign child_l = (CW+1)'({i_ff, 1'b1});
   assign child_r = child_l + 1'b1;

   // state and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ovalid_ff <= 1'b0;
         count_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
      end
      ret_ff <= ret_in; mode_ff <= mode_in; key_ff <= key_in; kval_ff <= kval_in;
      exp_ff <= exp_in; now_ff <= now_in; i_ff <= i_in; c_ff <= c_in;
      start_ff <= start_in; ent_i_ff <= ent_i_in; ent_c_ff <= ent_c_in;
      down_ff <= down_in; out_ff <= out_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   // sequencer
   always_comb begin
      logic [TIME_BITS-1:0] tmo;
      logic                 held;
      logic [CW-1:0]        lastslot;
      logic [SW-1:0]        parent;
      state_in = state_ff; ret_in = ret_ff; mode_in = mode_ff; key_in = key_ff;
      kval_in = kval_ff; exp_in = exp_ff; now_in = now_ff; count_in = count_ff;
      i_in = i_ff; c_in = c_ff; start_in = start_ff; ent_i_in = ent_i_ff;
      ent_c_in = ent_c_ff; down_in = down_ff; out_in = out_ff; ovalid_in = ovalid_ff;
      clr_in = clr_ff;
      h_we = 1'b0; h_wa = i_ff; h_wd = ent_i_ff; h_ra = i_ff;
      p_we = 1'b0; p_wa = key_of(ent_i_ff); p_wd = {1'b1, i_ff}; p_ra = key_ff;
      held = kval_ff && p_rd[SW];
      lastslot = count_ff - 1'b1;
      parent = SW'((i_ff - 1'b1) >> 1);
      tmo = '0;
      unique case (state_ff)
         // empty the key table once after reset
         S_CLEAR: begin
            p_we = 1'b1; p_wa = clr_ff; p_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == KW'(KEY_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               tmo = req.data.timeout[TIME_BITS-1:0];
               mode_in = req.data.mode;
               kval_in = (32'(req.data.key) < KEY_COUNT);
               key_in = kval_in ? KW'(req.data.key) : '0;
               now_in = req.data.now_time[TIME_BITS-1:0];
               exp_in = {1'b0, now_in} + {1'b0, tmo};
               out_in = '0;
               state_in = (req.data.mode == MODE_SERVICE) ? S_SV_RD : S_LOOK;
            end
         end
         S_LOOK: begin
            p_ra = key_ff;
            state_in = S_LOOK_W;
         end
         S_LOOK_W: state_in = S_DISPATCH;
         S_DISPATCH: begin
            out_in.last = 1'b1;
            out_in.kind = KIND_STATUS;
            i_in = p_rd[SW-1:0];
            priority if (!kval_ff || (!held && mode_ff != MODE_ARM)) begin
               out_in.status = ST_NOT_FOUND;
               state_in = S_EMIT;
            end else if (mode_ff == MODE_CANCEL) begin
               out_in.kind = KIND_FIRED;
               out_in.fired_key = KEY_W'(key_ff);
               ret_in = S_EMIT;
               state_in = S_RM_RD;
            end else if (held) begin
               ent_i_in = {key_ff, exp_ff};
               start_in = p_rd[SW-1:0];
               ret_in = S_EMIT;
               state_in = S_WRITE_NEW;
               down_in = 1'b1;
            end else if (32'(count_ff) >= CAPACITY) begin
               out_in.status = ST_FULL;
               state_in = S_EMIT;
            end else begin
               i_in = SW'(count_ff);
               start_in = SW'(count_ff);
               ent_i_in = {key_ff, exp_ff};
               count_in = count_ff + 1'b1;
               ret_in = S_EMIT;
               down_in = 1'b0;
               state_in = S_WRITE_NEW;
            end
         end
         // place entry i and point its key at it, then settle
         S_WRITE_NEW: begin
            h_we = 1'b1; p_we = 1'b1;
            state_in = down_ff ? S_DN_RD : S_UP_RD;
         end
         // removal of slot i: drop the key, move last entry in
         S_RM_RD: begin
            h_ra = SW'(lastslot);
            p_we = 1'b1; p_wa = key_ff; p_wd = '0;
            state_in = S_RM_RD_W;
         end
         S_RM_RD_W: begin
            h_ra = SW'(lastslot);
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            count_in = lastslot;
            if (CW'(i_ff) != lastslot) begin
               ent_i_in = h_rd;
               start_in = i_ff;
               down_in = 1'b1;
               h_we = 1'b1; h_wd = h_rd;
               p_we = 1'b1; p_wa = key_of(h_rd);
               state_in = S_DN_RD;
            end else begin
               state_in = ret_ff;
            end
         end
         // sift down: compare children
         S_DN_RD: begin
            if (child_l >= (CW+1)'(count_ff)) begin
               state_in = (i_ff == start_ff) ? S_UP_RD : ret_ff;
            end else begin
               h_ra = SW'(child_l);
               c_in = SW'(child_l);
               state_in = S_DN_RD_W;
            end
         end
         S_DN_RD_W: begin
            h_ra = c_ff;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            ent_c_in = h_rd;
            if (child_r < (CW+1)'(count_ff)) begin
               h_ra = SW'(child_r);
               state_in = S_DN_CMP_W;
            end else begin
               state_in = S_DN_PICK;
            end
         end
         S_DN_CMP_W: begin
            if (exp_of(h_rd) < exp_of(ent_c_ff)) begin
               ent_c_in = h_rd;
               c_in = SW'(child_r);
            end
            state_in = S_DN_PICK;
         end
         S_DN_PICK: begin
            if (exp_of(ent_c_ff) < exp_of(ent_i_ff)) begin
               down_in = 1'b1;
               state_in = S_SWAP_A;
            end else begin
               state_in = (i_ff == start_ff) ? S_UP_RD : ret_ff;
            end
         end
         // sift up: compare with parent
         S_UP_RD: begin
            if (i_ff == '0) begin
               state_in = ret_ff;
            end else begin
               h_ra = parent;
               c_in = parent;
               state_in = S_UP_RD_W;
            end
         end
         S_UP_RD_W: begin
            h_ra = c_ff;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            ent_c_in = h_rd;
            state_in = S_UP_CMP_W;
         end
         S_UP_CMP_W: begin
            down_in = 1'b0;
            state_in = (exp_of(ent_i_ff) < exp_of(ent_c_ff)) ? S_SWAP_A : ret_ff;
         end
         S_UP_DEC: state_in = S_UP_RD;
         // swap entry i with entry c, one write per cycle
         S_SWAP_A: begin
            h_we = 1'b1; h_wa = c_ff; h_wd = ent_i_ff;
            p_we = 1'b1; p_wa = key_of(ent_i_ff); p_wd = {1'b1, c_ff};
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            h_we = 1'b1; h_wa = i_ff; h_wd = ent_c_ff;
            p_we = 1'b1; p_wa = key_of(ent_c_ff); p_wd = {1'b1, i_ff};
            state_in = S_SWAP_C;
         end
         S_SWAP_C: begin
            i_in = c_ff;
            state_in = down_ff ? S_DN_RD : S_UP_DEC;
         end
         // service: peek at root
         S_SV_RD: begin
            h_ra = '0;
            state_in = S_SV_RD_W;
         end
         S_SV_RD_W: begin
            h_ra = '0;
            state_in = S_SV_CHK;
         end
         S_SV_CHK: begin
            out_in = '0;
            if (count_ff != '0 && exp_of(h_rd) <= {1'b0, now_ff}) begin
               out_in.kind = KIND_FIRED;
               out_in.fired_key = KEY_W'(key_of(h_rd));
               key_in = key_of(h_rd);
               i_in = '0;
               ret_in = S_SV_RD;
               ovalid_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               out_in.kind = KIND_REPORT;
               out_in.last = 1'b1;
               if (count_ff == '0) begin
                  out_in.none_pending = 1'b1;
               end else begin
                  out_in.remaining = REM_W'(exp_of(h_rd) - {1'b0, now_ff});
               end
               ovalid_in = 1'b1;
               state_in = S_EMIT;
            end
         end
         // deliver result; fired service events continue with removal
         S_EMIT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
            end else if (rsp.ready) begin
               ovalid_in = 1'b0;
               if (out_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  ret_in = S_SV_RD;
                  state_in = S_RM_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== sv/tmh_ram.sv =====
// generic single write, single read RAM with registered read
// depends on nothing
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/tmh_checker.sv =====
// port-level checker for the timer heap engine, bound to the top level
// depends on tmh_pkg and timer_min_heap_engine_defines.svh
`include "timer_min_heap_engine_defines.svh"
module tmh_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input tmh_pkg::rsp_type rsp_data
);
   import tmh_pkg::*;
   `TMH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `TMH_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "accepted while busy")
   `TMH_ASSERT(a_no_overlap, clock, reset, rsp_valid |-> !req_ready, "input open with result pending")
   `TMH_ASSERT(a_kind_legal, clock, reset, rsp_valid |-> rsp_data.kind != KIND_UNUSED && rsp_data.status != ST_UNUSED, "illegal result code")
   `TMH_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_valid, "result right after reset")
endmodule

bind timer_min_heap_engine tmh_checker u_tmh_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ===== bench/timer_min_heap_engine_tb.sv =====
// self-checking bench for timer_min_heap_engine: directed and random timer operations
// depends on tmh_pkg, tmh_if and the engine rtl; holds its own heap predictor
`timescale 1ns / 100ps

// scoreboard: mirrors the timer heap and keeps the results still to come
class timer_heap_board;
   localparam int DEPTH = tmh_pkg::CAPACITY_DEF;
   localparam int KEYS  = tmh_pkg::KEY_COUNT_DEF;

   bit [tmh_pkg::KEY_W-1:0] slot_key[DEPTH];
   bit [tmh_pkg::REM_W-1:0] slot_due[DEPTH];
   int unsigned             key_slot[KEYS];
   bit                      key_held[KEYS];
   int unsigned             held_count;
   tmh_pkg::rsp_type        pending_rsp[$];
   int unsigned             errors, fired_total, full_total, reports_empty;

   function void clear();
      held_count = 0;
      foreach (key_held[k]) key_held[k] = 0;
      pending_rsp.delete();
   endfunction

   function void exchange(int unsigned a, int unsigned b);
      bit [tmh_pkg::KEY_W-1:0] k;
      bit [tmh_pkg::REM_W-1:0] d;
      k = slot_key[a];
      d = slot_due[a];
      slot_key[a] = slot_key[b];
      slot_due[a] = slot_due[b];
      slot_key[b] = k;
      slot_due[b] = d;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
   endfunction

   function bit sink_down(int unsigned i);
      int unsigned from, c;
      from = i;
      forever begin
         c = 2 * i + 1;
         if (c >= held_count) break;
         if (c + 1 < held_count && slot_due[c+1] < slot_due[c]) c++;
         if (!(slot_due[c] < slot_due[i])) break;
         exchange(c, i);
         i = c;
      end
      return i != from;
   endfunction

   function void bubble_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!(slot_due[i] < slot_due[p])) break;
         exchange(i, p);
         i = p;
      end
   endfunction

   function void reposition(int unsigned i);
      if (!sink_down(i)) bubble_up(i);
   endfunction

   function void drop_slot(int unsigned i);
      int unsigned tail;
      tail = held_count - 1;
      key_held[slot_key[i]] = 0;
      if (i != tail) begin
         slot_key[i] = slot_key[tail];
         slot_due[i] = slot_due[tail];
         key_slot[slot_key[i]] = i;
      end
      held_count = tail;
      if (i != tail) reposition(i);
   endfunction

   function void push_rsp(tmh_pkg::kind_type kd, int unsigned key, tmh_pkg::status_type st,
                           bit [tmh_pkg::REM_W-1:0] rem, bit none, bit fin);
      tmh_pkg::rsp_type r;
      r.kind = kd;
      r.fired_key = key[tmh_pkg::KEY_W-1:0];
      r.status = st;
      r.remaining = rem;
      r.none_pending = none;
      r.last = fin;
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // predict every result of one accepted request
   function void note_request(tmh_pkg::req_type q);
      bit [tmh_pkg::REM_W-1:0] due;
      int unsigned key, s;
      bit held;
      due = {1'b0, q.now_time} + {1'b0, q.timeout};
      key = q.key;
      held = key_held[key];
      case (tmh_pkg::mode_type'(q.mode))
         tmh_pkg::MODE_ARM: begin
            if (held) begin
               slot_due[key_slot[key]] = due;
               reposition(key_slot[key]);
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_OK, 0, 0, 1);
            end else if (held_count >= DEPTH) begin
               full_total++;
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_FULL, 0, 0, 1);
            end else begin
               s = held_count++;
               slot_key[s] = key;
               slot_due[s] = due;
               key_slot[key] = s;
               key_held[key] = 1;
               bubble_up(s);
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_OK, 0, 0, 1);
            end
         end
         tmh_pkg::MODE_MODIFY: begin
            if (!held) begin
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_NOT_FOUND, 0, 0, 1);
            end else begin
               slot_due[key_slot[key]] = due;
               reposition(key_slot[key]);
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_OK, 0, 0, 1);
            end
         end
         tmh_pkg::MODE_CANCEL: begin
            if (!held) begin
               push_rsp(tmh_pkg::KIND_STATUS, 0, tmh_pkg::ST_NOT_FOUND, 0, 0, 1);
            end else begin
               drop_slot(key_slot[key]);
               fired_total++;
               push_rsp(tmh_pkg::KIND_FIRED, key, tmh_pkg::ST_OK, 0, 0, 1);
            end
         end
         default: begin
            // expire everything due at or before now, earliest first
            while (held_count > 0 && slot_due[0] <= {1'b0, q.now_time}) begin
               push_rsp(tmh_pkg::KIND_FIRED, slot_key[0], tmh_pkg::ST_OK, 0, 0, 0);
               fired_total++;
               drop_slot(0);
            end
            if (held_count == 0) begin
               reports_empty++;
               push_rsp(tmh_pkg::KIND_REPORT, 0, tmh_pkg::ST_OK, 0, 1, 1);
            end else begin
               push_rsp(tmh_pkg::KIND_REPORT, 0, tmh_pkg::ST_OK,
                        slot_due[0] - {1'b0, q.now_time}, 0, 1);
            end
         end
      endcase
   endfunction

   // compare one accepted result with the oldest prediction
   function void check_response(tmh_pkg::rsp_type got);
      tmh_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         errors++;
         $error("unexpected result transaction kind=%0d", got.kind);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.kind !== want.kind) begin
         errors++;
         $error("kind: expected %0d actual %0d", want.kind, got.kind);
      end
      if (got.fired_key !== want.fired_key) begin
         errors++;
         $error("fired_key: expected %0d actual %0d", want.fired_key, got.fired_key);
      end
      if (got.status !== want.status) begin
         errors++;
         $error("status: expected %0d actual %0d", want.status, got.status);
      end
      if (got.remaining !== want.remaining) begin
         errors++;
         $error("remaining: expected %0d actual %0d", want.remaining, got.remaining);
      end
      if (got.none_pending !== want.none_pending) begin
         errors++;
         $error("none_pending: expected %0d actual %0d", want.none_pending, got.none_pending);
      end
      if (got.last !== want.last) begin
         errors++;
         $error("last: expected %0d actual %0d", want.last, got.last);
      end
   endfunction
endclass

module timer_min_heap_engine_tb;
   import tmh_pkg::*;

   localparam int RANDOM_ITEMS = 410;
   localparam int IDLE_LIMIT   = 60000;
   localparam int HOLD_CYCLES  = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmh_if #(.PAYLOAD_TYPE(req_type)) req_if (clock);
   tmh_if #(.PAYLOAD_TYPE(rsp_type)) rsp_if (clock);

   timer_min_heap_engine u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   timer_heap_board board = new();

   int unsigned burst_left = 0;
   int unsigned sent_count = 0;
   int unsigned idle_cycles = 0;
   bit          hold_request = 0;
   bit [31:0]   now_stamp = 0;

   always #5 clock = ~clock;

   // one request transaction, then maybe a gap between bursts
   task automatic send_req(input mode_type m, input int unsigned key,
                           input bit [31:0] tmo, input bit [31:0] now);
      req_type r;
      r.mode = m;
      r.key = key[KEY_W-1:0];
      r.timeout = tmo;
      r.now_time = now;
      req_if.data = r;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(r);
      sent_count++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(0, 30)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // random request, mostly on a small key pool with time moving forward
   task automatic send_random();
      int unsigned pick, key;
      bit [31:0] tmo;
      mode_type m;
      pick = $urandom_range(0, 99);
      if (pick < 45) m = MODE_ARM;
      else if (pick < 60) m = MODE_MODIFY;
      else if (pick < 75) m = MODE_CANCEL;
      else m = MODE_SERVICE;
      key = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 47) : $urandom_range(0, 1023);
      if ($urandom_range(0, 19) == 0) begin
         tmo = $urandom();
         now_stamp = $urandom();
      end else begin
         tmo = $urandom_range(0, 150);
         now_stamp = now_stamp + $urandom_range(0, 25);
      end
      send_req(m, key, tmo, now_stamp);
   endtask

   // receiver: stall pattern, long hold-off on request, check on accept
   initial begin
      int unsigned phase;
      rsp_if.ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end
         phase++;
         if ((phase / 200) % 3 == 2) rsp_if.ready = 1'b1;
         else rsp_if.ready = ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_response(rsp_if.data);
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned settle_wait;
      req_if.valid = 1'b0;
      req_if.data = '0;
      board.clear();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every operation, equal expiries, empty report
      send_req(MODE_SERVICE, 0, 0, 0);
      send_req(MODE_ARM, 0, 0, 0);
      send_req(MODE_ARM, 7, 0, 0);
      send_req(MODE_ARM, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(MODE_ARM, 12, 5, 3);
      send_req(MODE_ARM, 13, 4, 4);
      send_req(MODE_MODIFY, 1023, 32'hFFFF_FFFF, 32'h0);
      send_req(MODE_MODIFY, 9, 1, 1);
      send_req(MODE_CANCEL, 9, 0, 0);
      send_req(MODE_ARM, 7, 0, 0);
      send_req(MODE_SERVICE, 0, 0, 0);
      send_req(MODE_SERVICE, 0, 0, 8);
      send_req(MODE_MODIFY, 1023, 32'h5555_5555, 32'hAAAA_AAAA);
      send_req(MODE_SERVICE, 0, 0, 32'h1234_5678);
      send_req(MODE_CANCEL, 1023, 0, 0);
      send_req(MODE_CANCEL, 1023, 0, 0);
      send_req(MODE_ARM, 512, 100, 32'hFFFF_FF00);
      send_req(MODE_SERVICE, 0, 0, 32'hFFFF_FFFF);
      send_req(MODE_SERVICE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random part, with one long receiver hold-off part way through
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) hold_request = 1;
         send_random();
      end
      req_if.valid = 1'b0;

      wait (board.pending_rsp.size() == 0);
      settle_wait = 0;
      while (settle_wait < 200) begin
         @(posedge clock);
         settle_wait++;
      end

      $display("covered %0d requests, %0d timers fired, %0d full rejections, %0d empty reports",
               sent_count, board.fired_total, board.full_total, board.reports_empty);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
